// File: src/wcm_pkg.sv
// Shared constants, types and the command template table of the wildcard
// command matcher. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wcm_pkg;

    localparam int DEF_NUM_TEMPLATES = 9;
    localparam int DEF_TEMPLATE_LEN  = 32;
    localparam int DEF_MAX_PARAMS    = 6;
    localparam int DEF_LINE_LEN      = 256;

    localparam int TABLE_COUNT = 9;
    localparam int TEXT_BYTES  = 32;

    localparam logic [7:0] WILD_CHAR = 8'h24;
    localparam logic [8:0] CHAR_NONE = 9'h100;

    localparam logic [TEXT_BYTES*8-1:0] TMPL_TEXT [TABLE_COUNT] = '{
        256'("time set $/$/$ $:$:$"),
        256'("time get"),
        256'("light set $:$ $ $:$"),
        256'("light get"),
        256'("water set $:$ $"),
        256'("water repeat $"),
        256'("water get"),
        256'("temperature set $ $"),
        256'("temperature get")
    };

    localparam int TMPL_RAW_LEN [TABLE_COUNT] = '{20, 8, 19, 9, 15, 14, 9, 19, 15};

    typedef enum logic [1:0] {
        TS_ALIVE  = 2'd0,
        TS_FAILED = 2'd1,
        TS_EMPTY  = 2'd2
    } tmpl_state_t;

    typedef enum logic [1:0] {
        RS_MATCH    = 2'd0,
        RS_NO_MATCH = 2'd1,
        RS_EMPTY    = 2'd2,
        RS_TOO_LONG = 2'd3
    } result_status_t;

    typedef struct packed {
        logic       completed;
        logic       empty;
        logic [2:0] count;
    } lane_stat_t;

    function automatic logic [7:0] tmpl_byte(input int t, input int i);
        logic [7:0] b;
        b = 8'd0;
        if (t < TABLE_COUNT && i < TMPL_RAW_LEN[t])
        begin
            b = TMPL_TEXT[t][(TMPL_RAW_LEN[t] - 1 - i) * 8 +: 8];
        end
        return b;
    endfunction

endpackage
`default_nettype wire

// File: src/wcm_in_if.sv
// Input channel of the wildcard command matcher: one byte or end of line per beat.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface wcm_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] ch;

    modport source (output valid, output cmd, output ch, input ready);
    modport sink (input valid, input cmd, input ch, output ready);
endinterface
`default_nettype wire

// File: src/wcm_out_if.sv
// Result channel of the wildcard command matcher: one result item per beat.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface wcm_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [3:0] template_index;
    logic       param_valid;
    logic [2:0] param_number;
    logic [7:0] param_start;
    logic [7:0] param_length;
    logic       last;

    modport source (output valid, output status, output template_index,
                    output param_valid, output param_number, output param_start,
                    output param_length, output last, input ready);
    modport sink (input valid, input status, input template_index,
                  input param_valid, input param_number, input param_start,
                  input param_length, input last, output ready);
endinterface
`default_nettype wire

// File: src/wcm_lane.sv
// Matcher for one template: cursor state plus a small parameter memory.
// Depends on wcm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wcm_lane
    import wcm_pkg::*;
#(
    parameter int T            = 0,
    parameter int TEMPLATE_LEN = DEF_TEMPLATE_LEN,
    parameter int MAX_PARAMS   = DEF_MAX_PARAMS,
    parameter int CW           = 6,
    parameter int AW           = 3
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          byte_en,
    input  wire logic          clear,
    input  wire logic [7:0]    ch,
    input  wire logic [7:0]    pos_sat,
    input  wire logic [AW-1:0] rd_addr,
    output logic [15:0]        rd_data,
    output lane_stat_t         stat
);

    localparam int EFF_LEN = (TMPL_RAW_LEN[T] < TEMPLATE_LEN) ? TMPL_RAW_LEN[T] : TEMPLATE_LEN;

    logic [15:0] mem [MAX_PARAMS];
    logic [15:0] rd_data_reg;

    tmpl_state_t state_reg, state_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic inside_reg, inside_next;
    logic [2:0] count_reg, count_next;
    logic [7:0] start_reg, start_next;
    logic [7:0] len_reg, len_next;

    logic we;
    logic [3:0] wa;
    logic [15:0] wd;
    logic [8:0] cur_c;
    logic [8:0] nxt_c;
    logic [3:0] cnt4;

    function automatic logic [8:0] char_at(input int i);
        logic [8:0] r;
        r = CHAR_NONE;
        if (i < EFF_LEN)
        begin
            r = {1'b0, tmpl_byte(T, i)};
        end
        return r;
    endfunction

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        inside_next = inside_reg;
        count_next  = count_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        we          = 1'b0;
        wa          = 4'd0;
        wd          = 16'd0;
        cur_c       = char_at(int'(cur_reg));
        nxt_c       = char_at(int'(cur_reg) + 1);
        cnt4        = {1'b0, count_reg};
        if (clear)
        begin
            state_next  = TS_ALIVE;
            cur_next    = '0;
            inside_next = 1'b0;
            count_next  = 3'd0;
        end
        else if (byte_en && state_reg == TS_ALIVE)
        begin
            if (inside_reg)
            begin
                if (nxt_c != CHAR_NONE && ch == nxt_c[7:0])
                begin
                    inside_next = 1'b0;
                    cur_next    = CW'(cur_reg + CW'(2));
                end
                else if (cnt4 != 4'd0 && int'(cnt4) <= MAX_PARAMS)
                begin
                    len_next = (len_reg == 8'hFF) ? len_reg : len_reg + 8'd1;
                    we       = 1'b1;
                    wa       = cnt4 - 4'd1;
                    wd       = {start_reg, len_next};
                end
            end
            else if (int'(cur_reg) >= EFF_LEN)
            begin
                state_next = TS_FAILED;
            end
            else if (cur_c == {1'b0, WILD_CHAR})
            begin
                if (nxt_c != CHAR_NONE && ch == nxt_c[7:0])
                begin
                    state_next = TS_EMPTY;
                end
                else
                begin
                    inside_next = 1'b1;
                    if (int'(cnt4) < MAX_PARAMS)
                    begin
                        start_next = pos_sat;
                        len_next   = 8'd1;
                        we         = 1'b1;
                        wa         = cnt4;
                        wd         = {pos_sat, 8'd1};
                    end
                    if (count_reg != 3'd7)
                    begin
                        count_next = count_reg + 3'd1;
                    end
                end
            end
            else if (ch == cur_c[7:0])
            begin
                cur_next = CW'(cur_reg + CW'(1));
            end
            else
            begin
                state_next = TS_FAILED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= TS_ALIVE;
            cur_reg    <= '0;
            inside_reg <= 1'b0;
            count_reg  <= 3'd0;
        end
        else
        begin
            state_reg  <= state_next;
            cur_reg    <= cur_next;
            inside_reg <= inside_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg   <= start_next;
        len_reg     <= len_next;
        rd_data_reg <= mem[rd_addr];
        if (we)
        begin
            mem[wa[AW-1:0]] <= wd;
        end
    end

    assign rd_data = rd_data_reg;

    always_comb
    begin
        stat.empty     = (state_reg == TS_EMPTY);
        stat.count     = count_reg;
        stat.completed = 1'b0;
        if (state_reg == TS_ALIVE)
        begin
            if (inside_reg)
            begin
                stat.completed = (int'(cur_reg) + 1 == EFF_LEN);
            end
            else
            begin
                stat.completed = (int'(cur_reg) == EFF_LEN);
            end
        end
    end

endmodule
`default_nettype wire

// File: src/wildcard_command_matcher_unit.sv
// Top level of the wildcard command matcher: line position, template lanes and
// the result sequencer. Depends on wcm_pkg, wcm_in_if, wcm_out_if and wcm_lane.
//
//   Channel | Modport | Beat
//   req     | sink    | one line byte (cmd 0) or end of line (cmd 1)
//   rsp     | source  | one result item, last marks the end of a line's results
//
// While the sequencer is idle, a line byte is taken every cycle and updates
// all template lanes in parallel. End of line is decided in the cycle it is
// taken; each parameter item then passes through a lane memory read and the
// output load, and req is held off until the line's last item sits in the
// output register. Reset is asynchronous and needs no clearing pass. The output
// register holds an item while rsp.ready is low.
`timescale 1ns / 1ps
`default_nettype none
module wildcard_command_matcher_unit
    import wcm_pkg::*;
#(
    parameter int NUM_TEMPLATES = DEF_NUM_TEMPLATES,
    parameter int TEMPLATE_LEN  = DEF_TEMPLATE_LEN,
    parameter int MAX_PARAMS    = DEF_MAX_PARAMS,
    parameter int LINE_LEN      = DEF_LINE_LEN
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    wcm_in_if.sink    req,
    wcm_out_if.source rsp
);

    localparam int NUM_ACT = (NUM_TEMPLATES < TABLE_COUNT) ? NUM_TEMPLATES : TABLE_COUNT;
    localparam int CW      = $clog2(TEMPLATE_LEN + 2);
    localparam int AW      = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int PW      = $clog2(LINE_LEN + 2);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } seq_state_t;

    seq_state_t state_reg, state_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [1:0] res_status_reg, res_status_next;
    logic [3:0] res_idx_reg, res_idx_next;
    logic [3:0] res_cnt_reg, res_cnt_next;
    logic [3:0] k_reg, k_next;

    logic out_valid_reg, out_valid_next;
    logic [1:0] o_status_reg, o_status_next;
    logic [3:0] o_idx_reg, o_idx_next;
    logic o_pv_reg, o_pv_next;
    logic [2:0] o_pn_reg, o_pn_next;
    logic [7:0] o_ps_reg, o_ps_next;
    logic [7:0] o_pl_reg, o_pl_next;
    logic o_last_reg, o_last_next;

    logic acc;
    logic byte_en;
    logic eol;
    logic [7:0] pos_sat;
    lane_stat_t lane_stat [NUM_ACT];
    logic [15:0] lane_rd [NUM_ACT];
    logic [15:0] sel_rd;
    logic out_free;
    logic [1:0] dec_status;
    logic [3:0] dec_idx;
    logic [3:0] dec_cnt;
    logic found;

    assign req.ready = (state_reg == S_IDLE);
    assign acc       = req.valid && req.ready;
    assign eol       = acc && req.cmd;
    assign byte_en   = acc && !req.cmd && (int'(pos_reg) < LINE_LEN);
    assign pos_sat   = (int'(pos_reg) > 255) ? 8'hFF : pos_reg[7:0];
    assign out_free  = !out_valid_reg || rsp.ready;

    genvar g;
    generate
        for (g = 0; g < NUM_ACT; g++)
        begin : gen_lane
            wcm_lane #(
                .T            (g),
                .TEMPLATE_LEN (TEMPLATE_LEN),
                .MAX_PARAMS   (MAX_PARAMS),
                .CW           (CW),
                .AW           (AW)
            ) u_lane (
                .clk     (clk),
                .rst_n   (rst_n),
                .byte_en (byte_en),
                .clear   (eol),
                .ch      (req.ch),
                .pos_sat (pos_sat),
                .rd_addr (k_reg[AW-1:0]),
                .rd_data (lane_rd[g]),
                .stat    (lane_stat[g])
            );
        end
    endgenerate

    always_comb
    begin
        dec_status = RS_NO_MATCH;
        dec_idx    = 4'd0;
        dec_cnt    = 4'd0;
        found      = 1'b0;
        for (int t = 0; t < NUM_ACT; t++)
        begin
            if (!found)
            begin
                if (lane_stat[t].empty)
                begin
                    dec_status = RS_EMPTY;
                    found      = 1'b1;
                end
                else if (lane_stat[t].completed)
                begin
                    dec_status = RS_MATCH;
                    dec_idx    = 4'(t);
                    dec_cnt    = (int'(lane_stat[t].count) < MAX_PARAMS) ?
                                 {1'b0, lane_stat[t].count} : 4'(MAX_PARAMS);
                    found      = 1'b1;
                end
            end
        end
        if (int'(pos_reg) > LINE_LEN)
        begin
            dec_status = RS_TOO_LONG;
            dec_idx    = 4'd0;
            dec_cnt    = 4'd0;
        end
    end

    always_comb
    begin
        sel_rd = 16'd0;
        for (int t = 0; t < NUM_ACT; t++)
        begin
            if (res_idx_reg == 4'(t))
            begin
                sel_rd = lane_rd[t];
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_cnt_next    = res_cnt_reg;
        k_next          = k_reg;
        out_valid_next  = out_valid_reg;
        o_status_next   = o_status_reg;
        o_idx_next      = o_idx_reg;
        o_pv_next       = o_pv_reg;
        o_pn_next       = o_pn_reg;
        o_ps_next       = o_ps_reg;
        o_pl_next       = o_pl_reg;
        o_last_next     = o_last_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (acc && !req.cmd)
                begin
                    if (int'(pos_reg) <= LINE_LEN)
                    begin
                        pos_next = PW'(pos_reg + PW'(1));
                    end
                end
                else if (eol)
                begin
                    pos_next        = '0;
                    res_status_next = dec_status;
                    res_idx_next    = (dec_status == RS_MATCH) ? dec_idx : 4'd0;
                    res_cnt_next    = (dec_status == RS_MATCH) ? dec_cnt : 4'd0;
                    k_next          = 4'd0;
                    if (dec_status == RS_MATCH && dec_cnt != 4'd0)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_status_next  = res_status_reg;
                    o_idx_next     = res_idx_reg;
                    o_pv_next      = (res_cnt_reg != 4'd0);
                    o_pn_next      = (res_cnt_reg != 4'd0) ? k_reg[2:0] : 3'd0;
                    o_ps_next      = (res_cnt_reg != 4'd0) ? sel_rd[15:8] : 8'd0;
                    o_pl_next      = (res_cnt_reg != 4'd0) ? sel_rd[7:0] : 8'd0;
                    if (res_cnt_reg != 4'd0 && k_reg + 4'd1 != res_cnt_reg)
                    begin
                        o_last_next = 1'b0;
                        k_next      = k_reg + 4'd1;
                        state_next  = S_READ;
                    end
                    else
                    begin
                        o_last_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            k_reg         <= 4'd0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_cnt_reg    <= res_cnt_next;
        o_status_reg   <= o_status_next;
        o_idx_reg      <= o_idx_next;
        o_pv_reg       <= o_pv_next;
        o_pn_reg       <= o_pn_next;
        o_ps_reg       <= o_ps_next;
        o_pl_reg       <= o_pl_next;
        o_last_reg     <= o_last_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = o_status_reg;
    assign rsp.template_index = o_idx_reg;
    assign rsp.param_valid    = o_pv_reg;
    assign rsp.param_number   = o_pn_reg;
    assign rsp.param_start    = o_ps_reg;
    assign rsp.param_length   = o_pl_reg;
    assign rsp.last           = o_last_reg;

endmodule
`default_nettype wire

// File: tb/wcm_test_if.sv
// Testbench copy of nothing: the RTL interfaces are reused directly.
// This file holds the line-matching helpers shared by the test top; depends on wcm_pkg.
`timescale 1ns / 1ps
package wcm_test_pkg;
    import wcm_pkg::*;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] template_index;
        logic       param_valid;
        logic [2:0] param_number;
        logic [7:0] param_start;
        logic [7:0] param_length;
        logic       last;
    } match_result_t;

    class line_matcher_board;
        int          line_pos;
        int          cursor [9];
        tmpl_state_t lane_state [9];
        bit          in_param [9];
        int          pcount [9];
        int          pstart [9][6];
        int          plen [9][6];
        int          tlen [9];
        match_result_t pending [$];
        int          errors;

        function new();
            for (int t = 0; t < 9; t++)
            begin
                tlen[t] = TMPL_RAW_LEN[t];
            end
            errors = 0;
            clear_line();
        endfunction

        function void clear_line();
            line_pos = 0;
            for (int t = 0; t < 9; t++)
            begin
                cursor[t] = 0;
                lane_state[t] = TS_ALIVE;
                in_param[t] = 0;
                pcount[t] = 0;
                for (int k = 0; k < 6; k++)
                begin
                    pstart[t][k] = 0;
                    plen[t][k] = 0;
                end
            end
        endfunction

        function int tchar(int t, int i);
            if (i >= tlen[t])
            begin
                return 256;
            end
            return tmpl_byte(t, i);
        endfunction

        function void lane_byte(int t, int c);
            int cur;
            int nxt;
            int k;
            cur = cursor[t];
            nxt = tchar(t, cur + 1);
            if (lane_state[t] != TS_ALIVE)
            begin
                return;
            end
            if (in_param[t])
            begin
                if (nxt != 256 && c == nxt)
                begin
                    in_param[t] = 0;
                    cursor[t] = cur + 2;
                end
                else
                begin
                    k = pcount[t];
                    if (k > 0 && k <= 6 && plen[t][k-1] < 255)
                    begin
                        plen[t][k-1]++;
                    end
                end
                return;
            end
            if (cur >= tlen[t])
            begin
                lane_state[t] = TS_FAILED;
            end
            else if (tchar(t, cur) == WILD_CHAR)
            begin
                if (nxt != 256 && c == nxt)
                begin
                    lane_state[t] = TS_EMPTY;
                end
                else
                begin
                    in_param[t] = 1;
                    k = pcount[t];
                    if (k < 6)
                    begin
                        pstart[t][k] = line_pos > 255 ? 255 : line_pos;
                        plen[t][k] = 1;
                    end
                    if (k < 7)
                    begin
                        pcount[t] = k + 1;
                    end
                end
            end
            else if (c == tchar(t, cur))
            begin
                cursor[t] = cur + 1;
            end
            else
            begin
                lane_state[t] = TS_FAILED;
            end
        endfunction

        function void push(result_status_t st, int ti, bit pv, int pn, int ps, int pl,
                           bit lst);
            match_result_t r;
            r.status = st;
            r.template_index = 4'(ti);
            r.param_valid = pv;
            r.param_number = 3'(pn);
            r.param_start = 8'(ps);
            r.param_length = 8'(pl);
            r.last = lst;
            pending = {pending, r};
        endfunction

        function void note_input(bit cmd, logic [7:0] c);
            int cnt;
            bit done;
            if (!cmd)
            begin
                if (line_pos > DEF_LINE_LEN)
                begin
                    return;
                end
                if (line_pos == DEF_LINE_LEN)
                begin
                    line_pos = DEF_LINE_LEN + 1;
                    return;
                end
                for (int t = 0; t < 9; t++)
                begin
                    lane_byte(t, c);
                end
                line_pos++;
                return;
            end
            done = 0;
            if (line_pos > DEF_LINE_LEN)
            begin
                push(RS_TOO_LONG, 0, 0, 0, 0, 0, 1);
                done = 1;
            end
            for (int t = 0; t < 9 && !done; t++)
            begin
                if (lane_state[t] == TS_EMPTY)
                begin
                    push(RS_EMPTY, 0, 0, 0, 0, 0, 1);
                    done = 1;
                end
                else if (lane_state[t] == TS_ALIVE &&
                         (in_param[t] ? cursor[t] + 1 == tlen[t] : cursor[t] == tlen[t]))
                begin
                    cnt = pcount[t] < 6 ? pcount[t] : 6;
                    if (cnt == 0)
                    begin
                        push(RS_MATCH, t, 0, 0, 0, 0, 1);
                    end
                    for (int k = 0; k < cnt; k++)
                    begin
                        push(RS_MATCH, t, 1, k, pstart[t][k], plen[t][k], k + 1 == cnt);
                    end
                    done = 1;
                end
            end
            if (!done)
            begin
                push(RS_NO_MATCH, 0, 0, 0, 0, 0, 1);
            end
            clear_line();
        endfunction

        function void check_result(match_result_t got);
            match_result_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d", $time, got.status);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got != exp)
            begin
                errors++;
                $display("%0t: mismatch expected st=%0d ti=%0d pv=%0d pn=%0d ps=%0d pl=%0d l=%0d",
                         $time, exp.status, exp.template_index, exp.param_valid,
                         exp.param_number, exp.param_start, exp.param_length, exp.last);
                $display("%0t:          actual   st=%0d ti=%0d pv=%0d pn=%0d ps=%0d pl=%0d l=%0d",
                         $time, got.status, got.template_index, got.param_valid,
                         got.param_number, got.param_start, got.param_length, got.last);
            end
        endfunction
    endclass
endpackage

// File: tb/wildcard_command_matcher_unit_test.sv
// Top of the wildcard command matcher test: drives command lines, checks each result beat.
// Depends on wcm_pkg, wcm_in_if, wcm_out_if, wcm_test_pkg and the RTL top.
`timescale 1ns / 1ps
module wildcard_command_matcher_unit_test;
    import wcm_pkg::*;
    import wcm_test_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    bit   calm = 0;
    int   cycles = 0;
    int   lines_sent = 0;
    line_matcher_board board;

    wcm_in_if  req ();
    wcm_out_if rsp ();

    wildcard_command_matcher_unit DUT (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    always #5 clk = ~clk;

    initial
    begin
        req.valid = 0;
        req.cmd = 0;
        req.ch = 0;
        rsp.ready = 0;
        board = new();
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        match_result_t r;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            r.status = rsp.status;
            r.template_index = rsp.template_index;
            r.param_valid = rsp.param_valid;
            r.param_number = rsp.param_number;
            r.param_start = rsp.param_start;
            r.param_length = rsp.param_length;
            r.last = rsp.last;
            board.check_result(r);
        end
    end

    initial
    begin
        int stall;
        @(negedge clk);
        while (1)
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 15);
                rsp.ready <= 0;
                repeat (stall) @(negedge clk);
            end
            rsp.ready <= 1;
        end
    end

    task automatic send_beat(bit cmd, logic [7:0] c);
        if (!calm && $urandom_range(0, 12) == 0)
        begin
            req.valid <= 0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        req.valid <= 1;
        req.cmd <= cmd;
        req.ch <= c;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        board.note_input(cmd, c);
        @(negedge clk);
    endtask

    task automatic idle_req();
        req.valid <= 0;
    endtask

    task automatic send_line(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_beat(0, s[i]);
        end
        send_beat(1, 8'($urandom));
    endtask

    function automatic string rand_word(int maxn);
        string s;
        int n;
        s = "";
        n = $urandom_range(1, maxn);
        for (int i = 0; i < n; i++)
        begin
            s = {s, string'(byte'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                           : $urandom_range(48, 57)))};
        end
        return s;
    endfunction

    function automatic string fill_template(int t);
        string s;
        logic [7:0] b;
        s = "";
        for (int i = 0; i < TMPL_RAW_LEN[t]; i++)
        begin
            b = tmpl_byte(t, i);
            if (b == WILD_CHAR)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    s = s;
                end
                else
                begin
                    s = {s, rand_word(6)};
                end
            end
            else if ($urandom_range(0, 60) == 0)
            begin
                s = {s, string'(byte'($urandom))};
            end
            else
            begin
                s = {s, string'(b)};
            end
        end
        return s;
    endfunction

    task automatic send_long(int n);
        for (int i = 0; i < n; i++)
        begin
            send_beat(0, 8'($urandom));
        end
        send_beat(1, 8'd0);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        send_line("time get");
        send_line("");
        send_line("time set 1/2/3 4:5:6");
        send_line("light set 1:2 3 4:5");
        send_line("light get");
        send_line("water set 7:8 9");
        send_line("water repeat abc");
        send_line("water get");
        send_line("temperature set 1 2");
        send_line("temperature get");
        send_line("water set :8 9");
        send_line("time set 1/2/3 4:5");
        send_line("temperature set 1 ");
        send_line("time gex");
        send_beat(0, 8'hff);
        send_beat(0, 8'h00);
        send_beat(1, 8'hff);
        idle_req();
        while (board.pending.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
        for (int n = 0; n < 4; n++)
        begin
            if (n == 3)
            begin
                calm = 1;
            end
            case ($urandom_range(0, 9))
                0: send_line(rand_word(10));
                1: send_long($urandom_range(1, 40));
                default: send_line(fill_template($urandom_range(0, 8)));
            endcase
        end
        idle_req();
        while (board.pending.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
